>>> rtl/core/sps_pkg.sv
// Shared types, codes and phase tables for the stepper phase sequencer.
// Depends on nothing; used by sps_update and stepper_phase_sequencer.
`default_nettype none

package sps_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;

   localparam int CMD_W   = 3;
   localparam int DIR_W   = 2;
   localparam int MODE_W  = 2;
   localparam int LIMIT_W = 31;
   localparam int PHASE_W = 4;
   localparam int COIL_W  = 4;
   localparam int OUT_COUNT_W = 32;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 80;

   localparam logic [PHASE_W-1:0] PH_UNSET = 4'd8;
   localparam logic [PHASE_W-1:0] PH_OFF   = 4'd15;

   localparam logic [MODE_W-1:0] MODE_HALF  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAVE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TWO   = 2'd2;

   localparam logic CSR_EXCITATION_MODE = 1'b0;
   localparam logic CSR_STEP_LIMIT      = 1'b1;

   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'b01;
   localparam logic signed [DIR_W-1:0] MOVED_NONE = 2'sb00;
   localparam logic signed [DIR_W-1:0] MOVED_FWD  = 2'sb01;
   localparam logic signed [DIR_W-1:0] MOVED_BWD  = 2'sb11;

   typedef enum logic [CMD_W-1:0] {
      CMD_LIMITED_STEP = 3'd0,
      CMD_FORCED_STEP  = 3'd1,
      CMD_POWER_ON     = 3'd2,
      CMD_POWER_OFF    = 3'd3,
      CMD_SET_HOME     = 3'd4
   } cmd_type;

   // Sequencer state other than the two counters.
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [COIL_W-1:0]  coils;
      logic               powered;
      logic               homed;
   } state_type;

   // Coil pattern per phase: bit 3 is A1, bit 2 A2, bit 1 B1, bit 0 B2.
   function automatic logic [COIL_W-1:0] coil_pattern(input logic [2:0] ph);
      logic [COIL_W-1:0] pat;
      case (ph)
         3'd0: pat = 4'h5;
         3'd1: pat = 4'h4;
         3'd2: pat = 4'h6;
         3'd3: pat = 4'h2;
         3'd4: pat = 4'hA;
         3'd5: pat = 4'h8;
         3'd6: pat = 4'h9;
         3'd7: pat = 4'h1;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

   function automatic logic [PHASE_W-1:0] next_forward(input logic [MODE_W-1:0] mode,
                                                      input logic [PHASE_W-1:0] ph);
      logic               valid;
      logic [PHASE_W-1:0] nxt;
      valid = (ph < 4'd8);
      case (mode)
         MODE_TWO: begin
            if (!valid || ph >= 4'd6)  nxt = 4'd0;
            else if (ph < 4'd2)        nxt = 4'd2;
            else if (ph < 4'd4)        nxt = 4'd4;
            else                       nxt = 4'd6;
         end
         MODE_WAVE: begin
            if (!valid || ph == 4'd0 || ph >= 4'd7) nxt = 4'd1;
            else if (ph < 4'd3)                     nxt = 4'd3;
            else if (ph < 4'd5)                     nxt = 4'd5;
            else                                    nxt = 4'd7;
         end
         default: begin
            if (!valid || ph >= 4'd7) nxt = 4'd0;
            else                      nxt = ph + 4'd1;
         end
      endcase
      return nxt;
   endfunction

   function automatic logic [PHASE_W-1:0] next_backward(input logic [MODE_W-1:0] mode,
                                                       input logic [PHASE_W-1:0] ph);
      logic [PHASE_W-1:0] nxt;
      case (mode)
         MODE_TWO: begin
            if (ph == PH_OFF || ph < 4'd2) nxt = 4'd6;
            else if (ph == PH_UNSET)       nxt = 4'd4;
            else if (ph < 4'd4)            nxt = 4'd0;
            else if (ph < 4'd6)            nxt = 4'd2;
            else                           nxt = 4'd4;
         end
         MODE_WAVE: begin
            if (ph == PH_OFF || ph < 4'd2) nxt = 4'd7;
            else if (ph == PH_UNSET)       nxt = 4'd5;
            else if (ph < 4'd4)            nxt = 4'd1;
            else if (ph < 4'd6)            nxt = 4'd3;
            else                           nxt = 4'd5;
         end
         default: begin
            if (ph == PH_OFF || ph == 4'd0) nxt = 4'd7;
            else if (ph == PH_UNSET)        nxt = 4'd0;
            else                            nxt = ph - 4'd1;
         end
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/stepper_phase_sequencer.sv
// Top level of the bipolar stepper phase sequencer: handshakes, state and result registers.
// Depends on sps_pkg and sps_update.
//
// Usage: each transfer on the req_ channel carries one command (limited step, forced
// step, power on, power off, set home) and a step direction. For every command one
// result leaves on the rsp_ channel: the coil levels, the phase code, the step taken,
// the motor and axis counts and the power, homed and accepted flags, all as they
// stand after that command.
// The csr_ channel writes the excitation mode (index 0) and the step limit (index 1);
// it is always ready and is to be written only while no command is in flight.
// A command taken on req_ is held in the input register; it is then applied to the state
// by combinational logic, and its result lands in the output register once that register
// is free. One command is taken per cycle while the receiver does not stall.
// Reset clears both counters, powers the coils down, marks the phase unset and
// sets the excitation mode and step limit to zero; no result is pending after it.
// When the receiver stalls, the result waits in the output register and one further
// command waits in the input register; req_tready then falls until rsp_tready returns.
`default_nettype none

module stepper_phase_sequencer
   import sps_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [2:0] command, [4:3] direction, [7:5] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] coil_a1, [1] coil_a2, [2] coil_b1, [3] coil_b2, [7:4] phase_code,
   // [9:8] moved, [41:10] motor_count, [73:42] axis_count, [74] powered,
   // [75] homed, [76] accepted, [79:77] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [LIMIT_W-1:0]    csr_data
);

   logic                    in_valid_ff;
   logic [CMD_W-1:0]        in_cmd_ff;
   logic [DIR_W-1:0]        in_dir_ff;
   logic                    out_valid_ff;
   logic [RSP_DATA_W-1:0]   out_data_ff;
   logic [RSP_DATA_W-1:0]   out_data_in;
   logic [MODE_W-1:0]       mode_ff;
   logic [LIMIT_W-1:0]      limit_ff;
   state_type               state_ff;
   state_type               state_in;
   logic [COUNT_BITS-1:0]   motor_ff;
   logic [COUNT_BITS-1:0]   motor_in;
   logic [COUNT_BITS-1:0]   axis_ff;
   logic [COUNT_BITS-1:0]   axis_in;
   logic signed [DIR_W-1:0] moved;
   logic                    accepted;
   logic                    out_free;
   logic                    advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   sps_update #(
      .COUNT_BITS(COUNT_BITS)
   ) u_update (
      .cmd       (in_cmd_ff),
      .dir       (in_dir_ff),
      .mode      (mode_ff),
      .limit     (limit_ff),
      .cur       (state_ff),
      .motor_cur (motor_ff),
      .axis_cur  (axis_ff),
      .nxt       (state_in),
      .motor_nxt (motor_in),
      .axis_nxt  (axis_in),
      .moved     (moved),
      .accepted  (accepted)
   );

   // Counts narrower than the output field are zero-extended, wider ones truncated.
   assign out_data_in = {3'b000, accepted, state_in.homed, state_in.powered,
                         OUT_COUNT_W'(axis_in), OUT_COUNT_W'(motor_in), moved,
                         state_in.phase, state_in.coils[0], state_in.coils[1],
                         state_in.coils[2], state_in.coils[3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tdata[CMD_W-1:0];
         in_dir_ff <= req_tdata[CMD_W+DIR_W-1:CMD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= PH_UNSET;
         state_ff.coils   <= '0;
         state_ff.powered <= 1'b0;
         state_ff.homed   <= 1'b0;
         motor_ff         <= '0;
         axis_ff          <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         motor_ff <= motor_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HALF;
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXCITATION_MODE: mode_ff  <= csr_data[MODE_W-1:0];
            CSR_STEP_LIMIT:      limit_ff <= csr_data;
            default:             limit_ff <= limit_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sps_update.sv
// Next-state logic of the stepper phase sequencer for one command.
// Depends on sps_pkg for the command codes, state struct and phase tables.
`default_nettype none

module sps_update
   import sps_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic [CMD_W-1:0]      cmd,
   input  wire logic [DIR_W-1:0]      dir,
   input  wire logic [MODE_W-1:0]     mode,
   input  wire logic [LIMIT_W-1:0]    limit,
   input  wire state_type             cur,
   input  wire logic [COUNT_BITS-1:0] motor_cur,
   input  wire logic [COUNT_BITS-1:0] axis_cur,
   output state_type                  nxt,
   output logic [COUNT_BITS-1:0]      motor_nxt,
   output logic [COUNT_BITS-1:0]      axis_nxt,
   output logic signed [DIR_W-1:0]    moved,
   output logic                       accepted
);

   localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

   cmd_type            cmd_code;
   logic               is_step;
   logic               forced;
   logic               motor_neg;
   logic               fwd_ok;
   logic               bwd_ok;
   logic               take_fwd;
   logic               take_bwd;
   logic [PHASE_W-1:0] step_phase;
   logic [CMP_W-1:0]   motor_ext;
   logic [CMP_W-1:0]   limit_ext;

   assign cmd_code  = cmd_type'(cmd);
   assign forced    = (cmd_code == CMD_FORCED_STEP);
   assign is_step   = (cmd_code == CMD_LIMITED_STEP) || forced;
   assign motor_neg = motor_cur[COUNT_BITS-1];
   assign motor_ext = CMP_W'(motor_cur);
   assign limit_ext = CMP_W'(limit);

   // A negative count always lies below the limit.
   assign fwd_ok   = forced || motor_neg || (motor_ext < limit_ext);
   assign bwd_ok   = forced || (!motor_neg && (motor_cur != '0));
   assign take_fwd = is_step && (dir == DIR_FORWARD) && fwd_ok;
   assign take_bwd = is_step && dir[1] && bwd_ok;

   always_comb begin
      if (take_fwd)      step_phase = next_forward(mode, cur.phase);
      else if (take_bwd) step_phase = next_backward(mode, cur.phase);
      else               step_phase = cur.phase;
   end

   always_comb begin
      nxt       = cur;
      motor_nxt = motor_cur;
      axis_nxt  = axis_cur;
      moved     = MOVED_NONE;
      accepted  = 1'b1;
      case (cmd_code)
         CMD_LIMITED_STEP, CMD_FORCED_STEP: begin
            // An invalid phase with no step taken leaves the coils alone.
            if (step_phase < PH_UNSET) begin
               nxt.phase = step_phase;
               if (cur.powered) nxt.coils = coil_pattern(step_phase[2:0]);
            end
            if (take_fwd) begin
               moved     = MOVED_FWD;
               motor_nxt = motor_cur + COUNT_BITS'(1);
               if (!forced) axis_nxt = axis_cur + COUNT_BITS'(1);
            end else if (take_bwd) begin
               moved     = MOVED_BWD;
               motor_nxt = motor_cur - COUNT_BITS'(1);
               if (!forced) axis_nxt = axis_cur - COUNT_BITS'(1);
            end
         end
         CMD_POWER_ON: begin
            nxt.powered = 1'b1;
         end
         CMD_POWER_OFF: begin
            nxt.powered = 1'b0;
            nxt.coils   = '0;
            nxt.phase   = PH_OFF;
            nxt.homed   = 1'b0;
         end
         CMD_SET_HOME: begin
            if (cur.powered && (cur.phase < PH_UNSET)) begin
               motor_nxt = '0;
               axis_nxt  = '0;
               nxt.homed = 1'b1;
            end else begin
               accepted = 1'b0;
            end
         end
         default: begin
            accepted = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire
